// ===== sv/hex27sf_pkg.sv =====
// Shared types, constants and the node table of the hex27 shape-function evaluator.
// No dependencies; every other file takes names from here by package scope or by import.
`default_nettype none

package hex27sf_pkg;

   localparam int FRAC_BITS  = 14;
   localparam int COORD_W    = 16;
   localparam int VALUE_W    = 16;
   localparam int NODE_W     = 5;
   localparam int NODE_COUNT = 27;
   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);

   // x +/- 2^F needs one bit over whichever of x and 2^F is wider
   localparam int XS_W  = (FRAC_BITS + 2 > COORD_W + 1) ? FRAC_BITS + 2 : COORD_W + 1;
   localparam int NUM_A = COORD_W + XS_W;
   localparam int NUM_B = ((2 * FRAC_BITS + 2 > 2 * COORD_W) ?
                           2 * FRAC_BITS + 2 : 2 * COORD_W) + 2;
   localparam int NUM_W = (NUM_A > NUM_B) ? NUM_A : NUM_B;
   localparam int MAG_W = NUM_W - 1;
   localparam int PROD_W = 3 * MAG_W;
   localparam int RND_W  = PROD_W + 1;
   localparam int SHIFT  = 6 * FRAC_BITS + 3;
   localparam int Q_W    = 40;
   localparam int VAL_W  = Q_W + 1;

   localparam logic signed [XS_W-1:0]  S_VAL = XS_W'(1) << FRAC_BITS;
   localparam logic signed [NUM_W-1:0] SSQ   = NUM_W'(1) << (2 * FRAC_BITS);
   localparam logic [RND_W-1:0] ROUND_HALF   = RND_W'(1) << (SHIFT - 1);

   localparam longint SAT_HI_L = (FRAC_BITS >= 15) ? 32767 : (longint'(1) << FRAC_BITS);
   localparam longint SAT_LO_L = (FRAC_BITS >= 18) ? -32768 :
                                 -(longint'(1) << (FRAC_BITS - 3));
   localparam logic signed [VAL_W-1:0]   SAT_HI    = VAL_W'(SAT_HI_L);
   localparam logic signed [VAL_W-1:0]   SAT_LO    = VAL_W'(SAT_LO_L);
   localparam logic signed [VALUE_W-1:0] SAT_HI_16 = VALUE_W'(SAT_HI_L);
   localparam logic signed [VALUE_W-1:0] SAT_LO_16 = VALUE_W'(SAT_LO_L);

   typedef enum logic [1:0] {
      POS_MINUS  = 2'd0,
      POS_CENTER = 2'd1,
      POS_PLUS   = 2'd2
   } pos_code_type;

   typedef struct packed {
      pos_code_type xi;
      pos_code_type eta;
      pos_code_type zeta;
   } node_pos_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] xi_coord;
      logic signed [COORD_W-1:0] eta_coord;
      logic signed [COORD_W-1:0] zeta_coord;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]         node_index;
      logic signed [VALUE_W-1:0] shape_value;
      logic                      last_node;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] node;
   } tag_type;

   typedef struct packed {
      tag_type    tag;
      req_type    coord;
   } issue_type;

   typedef struct packed {
      tag_type           tag;
      logic              neg;
      logic [MAG_W-1:0]  mag_xi;
      logic [MAG_W-1:0]  mag_eta;
      logic [MAG_W-1:0]  mag_zeta;
   } factor_type;

   typedef struct packed {
      tag_type           tag;
      logic              neg;
      logic [RND_W-1:0]  sum;
   } product_type;

   function automatic node_pos_type node_pos(input logic [NODE_W-1:0] node);
      node_pos_type p;
      unique case (node)
         5'd0:    p = '{POS_MINUS,  POS_MINUS,  POS_MINUS};
         5'd1:    p = '{POS_PLUS,   POS_MINUS,  POS_MINUS};
         5'd2:    p = '{POS_PLUS,   POS_PLUS,   POS_MINUS};
         5'd3:    p = '{POS_MINUS,  POS_PLUS,   POS_MINUS};
         5'd4:    p = '{POS_MINUS,  POS_MINUS,  POS_PLUS};
         5'd5:    p = '{POS_PLUS,   POS_MINUS,  POS_PLUS};
         5'd6:    p = '{POS_PLUS,   POS_PLUS,   POS_PLUS};
         5'd7:    p = '{POS_MINUS,  POS_PLUS,   POS_PLUS};
         5'd8:    p = '{POS_CENTER, POS_MINUS,  POS_MINUS};
         5'd9:    p = '{POS_PLUS,   POS_CENTER, POS_MINUS};
         5'd10:   p = '{POS_CENTER, POS_PLUS,   POS_MINUS};
         5'd11:   p = '{POS_MINUS,  POS_CENTER, POS_MINUS};
         5'd12:   p = '{POS_MINUS,  POS_MINUS,  POS_CENTER};
         5'd13:   p = '{POS_PLUS,   POS_MINUS,  POS_CENTER};
         5'd14:   p = '{POS_PLUS,   POS_PLUS,   POS_CENTER};
         5'd15:   p = '{POS_MINUS,  POS_PLUS,   POS_CENTER};
         5'd16:   p = '{POS_CENTER, POS_MINUS,  POS_PLUS};
         5'd17:   p = '{POS_PLUS,   POS_CENTER, POS_PLUS};
         5'd18:   p = '{POS_CENTER, POS_PLUS,   POS_PLUS};
         5'd19:   p = '{POS_MINUS,  POS_CENTER, POS_PLUS};
         5'd20:   p = '{POS_CENTER, POS_CENTER, POS_CENTER};
         5'd21:   p = '{POS_CENTER, POS_CENTER, POS_MINUS};
         5'd22:   p = '{POS_CENTER, POS_CENTER, POS_PLUS};
         5'd23:   p = '{POS_MINUS,  POS_CENTER, POS_CENTER};
         5'd24:   p = '{POS_PLUS,   POS_CENTER, POS_CENTER};
         5'd25:   p = '{POS_CENTER, POS_MINUS,  POS_CENTER};
         5'd26:   p = '{POS_CENTER, POS_PLUS,   POS_CENTER};
         default: p = '{POS_CENTER, POS_CENTER, POS_CENTER};
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== sv/hex27sf_sequencer.sv =====
// Input capture and node sequencer: holds the point, issues nodes 0..26 one per cycle.
// Depends on hex27sf_pkg.
`default_nettype none

module hex27sf_sequencer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire hex27sf_pkg::req_type req_word,
   output logic                      busy,
   output hex27sf_pkg::issue_type    issue
);

   logic                           active_ff, active_in;
   logic [hex27sf_pkg::NODE_W-1:0] node_ff, node_in;
   hex27sf_pkg::req_type           coord_ff, coord_in;

   // a new point may be taken in the cycle that node 26 goes out
   assign busy = active_ff && (node_ff != hex27sf_pkg::LAST_NODE);

   always_comb begin
      active_in = active_ff;
      node_in   = node_ff;
      coord_in  = coord_ff;
      if (busy) begin
         node_in = node_ff + hex27sf_pkg::NODE_W'(1);
      end else if (start) begin
         active_in = 1'b1;
         node_in   = '0;
         coord_in  = req_word;
      end else begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         node_ff   <= '0;
      end else begin
         active_ff <= active_in;
         node_ff   <= node_in;
      end
      coord_ff <= coord_in;
   end

   assign issue.tag.valid = active_ff;
   assign issue.tag.node  = node_ff;
   assign issue.coord     = coord_ff;

endmodule

`default_nettype wire

// ===== sv/hex27sf_factor.sv =====
// Two stages: 1-D quadratic factor numerators per axis, then sign and magnitudes.
// Depends on hex27sf_pkg.
`default_nettype none

module hex27sf_factor (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hex27sf_pkg::issue_type issue,
   output hex27sf_pkg::factor_type     factor
);

   // numerator over 2^(2F+1): x(x-s), 2(s^2-x^2) or x(x+s)
   function automatic logic signed [hex27sf_pkg::NUM_W-1:0] factor_num(
      input logic signed [hex27sf_pkg::COORD_W-1:0] x,
      input hex27sf_pkg::pos_code_type code
   );
      logic signed [hex27sf_pkg::XS_W-1:0]  xe;
      logic signed [hex27sf_pkg::XS_W-1:0]  t;
      logic signed [hex27sf_pkg::NUM_A-1:0] p;
      logic signed [hex27sf_pkg::NUM_W-1:0] pe;
      xe = hex27sf_pkg::XS_W'(x);
      case (code)
         hex27sf_pkg::POS_PLUS:  t = xe + hex27sf_pkg::S_VAL;
         hex27sf_pkg::POS_MINUS: t = xe - hex27sf_pkg::S_VAL;
         default:                t = xe;
      endcase
      p  = x * t;
      pe = hex27sf_pkg::NUM_W'(p);
      if (code == hex27sf_pkg::POS_CENTER) begin
         return (hex27sf_pkg::SSQ - pe) <<< 1;
      end
      return pe;
   endfunction

   function automatic logic [hex27sf_pkg::MAG_W-1:0] mag_of(
      input logic signed [hex27sf_pkg::NUM_W-1:0] n
   );
      logic signed [hex27sf_pkg::NUM_W-1:0] a;
      a = n[hex27sf_pkg::NUM_W-1] ? -n : n;
      return a[hex27sf_pkg::MAG_W-1:0];
   endfunction

   hex27sf_pkg::node_pos_type             pos;
   hex27sf_pkg::tag_type                  tag1_ff;
   logic signed [hex27sf_pkg::NUM_W-1:0]  num_xi_in, num_eta_in, num_zeta_in;
   logic signed [hex27sf_pkg::NUM_W-1:0]  num_xi_ff, num_eta_ff, num_zeta_ff;
   hex27sf_pkg::factor_type               factor_ff, factor_in;

   always_comb begin
      pos         = hex27sf_pkg::node_pos(issue.tag.node);
      num_xi_in   = factor_num(issue.coord.xi_coord, pos.xi);
      num_eta_in  = factor_num(issue.coord.eta_coord, pos.eta);
      num_zeta_in = factor_num(issue.coord.zeta_coord, pos.zeta);
   end

   always_comb begin
      factor_in.tag      = tag1_ff;
      factor_in.neg      = num_xi_ff[hex27sf_pkg::NUM_W-1] ^ num_eta_ff[hex27sf_pkg::NUM_W-1]
                           ^ num_zeta_ff[hex27sf_pkg::NUM_W-1];
      factor_in.mag_xi   = mag_of(num_xi_ff);
      factor_in.mag_eta  = mag_of(num_eta_ff);
      factor_in.mag_zeta = mag_of(num_zeta_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid       <= 1'b0;
         factor_ff.tag.valid <= 1'b0;
      end else begin
         tag1_ff.valid       <= issue.tag.valid;
         factor_ff.tag.valid <= factor_in.tag.valid;
      end
      tag1_ff.node       <= issue.tag.node;
      num_xi_ff          <= num_xi_in;
      num_eta_ff         <= num_eta_in;
      num_zeta_ff        <= num_zeta_in;
      factor_ff.tag.node <= factor_in.tag.node;
      factor_ff.neg      <= factor_in.neg;
      factor_ff.mag_xi   <= factor_in.mag_xi;
      factor_ff.mag_eta  <= factor_in.mag_eta;
      factor_ff.mag_zeta <= factor_in.mag_zeta;
   end

   assign factor = factor_ff;

endmodule

`default_nettype wire

// ===== sv/hex27sf_product.sv =====
// Three stages: first product, two partial products of the second, sum plus rounding half.
// Depends on hex27sf_pkg.
`default_nettype none

module hex27sf_product (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire hex27sf_pkg::factor_type factor,
   output hex27sf_pkg::product_type     product
);

   localparam int MW = hex27sf_pkg::MAG_W;

   hex27sf_pkg::tag_type   tag3_ff, tag4_ff;
   logic                   neg3_ff, neg4_ff;
   logic [2*MW-1:0]        p01_ff, p01_in;
   logic [MW-1:0]          m2_ff;
   logic [2*MW-1:0]        pp_lo_ff, pp_lo_in, pp_hi_ff, pp_hi_in;
   hex27sf_pkg::product_type product_ff, product_in;

   always_comb begin
      p01_in   = factor.mag_xi * factor.mag_eta;
      pp_lo_in = p01_ff[MW-1:0] * m2_ff;
      pp_hi_in = p01_ff[2*MW-1:MW] * m2_ff;
      product_in.tag = tag4_ff;
      product_in.neg = neg4_ff;
      product_in.sum = hex27sf_pkg::RND_W'(pp_lo_ff)
                       + (hex27sf_pkg::RND_W'(pp_hi_ff) << MW)
                       + hex27sf_pkg::ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag3_ff.valid        <= 1'b0;
         tag4_ff.valid        <= 1'b0;
         product_ff.tag.valid <= 1'b0;
      end else begin
         tag3_ff.valid        <= factor.tag.valid;
         tag4_ff.valid        <= tag3_ff.valid;
         product_ff.tag.valid <= product_in.tag.valid;
      end
      tag3_ff.node        <= factor.tag.node;
      neg3_ff             <= factor.neg;
      p01_ff              <= p01_in;
      m2_ff               <= factor.mag_zeta;
      tag4_ff.node        <= tag3_ff.node;
      neg4_ff             <= neg3_ff;
      pp_lo_ff            <= pp_lo_in;
      pp_hi_ff            <= pp_hi_in;
      product_ff.tag.node <= product_in.tag.node;
      product_ff.neg      <= product_in.neg;
      product_ff.sum      <= product_in.sum;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// ===== sv/hex27sf_round_sat.sv =====
// Output stage: drops the fraction, applies the sign, saturates and registers the word.
// Depends on hex27sf_pkg.
`default_nettype none

module hex27sf_round_sat (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire hex27sf_pkg::product_type product,
   output logic                          rsp_strobe,
   output hex27sf_pkg::rsp_type          rsp_word
);

   logic [hex27sf_pkg::RND_W-1:0]        qvec;
   logic                                 big;
   logic [hex27sf_pkg::Q_W-1:0]          q;
   logic signed [hex27sf_pkg::VAL_W-1:0] qs, v;
   logic signed [hex27sf_pkg::VAL_W-1:0] sat;
   logic                                 strobe_ff;
   hex27sf_pkg::rsp_type                 word_ff, word_in;

   always_comb begin
      qvec = product.sum >> hex27sf_pkg::SHIFT;
      big  = |(qvec >> hex27sf_pkg::Q_W);
      q    = qvec[hex27sf_pkg::Q_W-1:0];
      qs   = $signed({1'b0, q});
      v    = product.neg ? -qs : qs;
      if (big) begin
         sat = product.neg ? hex27sf_pkg::SAT_LO : hex27sf_pkg::SAT_HI;
      end else if (v > hex27sf_pkg::SAT_HI) begin
         sat = hex27sf_pkg::SAT_HI;
      end else if (v < hex27sf_pkg::SAT_LO) begin
         sat = hex27sf_pkg::SAT_LO;
      end else begin
         sat = v;
      end
      word_in.node_index  = product.tag.node;
      word_in.shape_value = sat[hex27sf_pkg::VALUE_W-1:0];
      word_in.last_node   = (product.tag.node == hex27sf_pkg::LAST_NODE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= product.tag.valid;
      end
      word_ff <= word_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = word_ff;

endmodule

`default_nettype wire

// ===== sv/hex27_shape_function_eval_core.sv =====
// A point (xi, eta, zeta) is taken at a clock edge with start high and busy low. Its 27
// shape-function values then come out in node order 0..26, one word per cycle on
// consecutive cycles, each marked by rsp_strobe for one cycle; the receiver cannot stall,
// so each word must be taken when shown. Node 0 reaches the result ports through the
// factor, product and output stages. A point occupies the node sequencer until all its
// 27 nodes are issued; the next point is accepted in the cycle that node 26 is
// issued, so back-to-back points give an unbroken stream of one word per cycle.
// Depends on hex27sf_pkg, hex27sf_sequencer, hex27sf_factor, hex27sf_product and
// hex27sf_round_sat.
`default_nettype none

module hex27_shape_function_eval_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire hex27sf_pkg::req_type req_word,
   output logic                      busy,
   output logic                      rsp_strobe,
   output hex27sf_pkg::rsp_type      rsp_word
);

   localparam int LATENCY = 7;

   hex27sf_pkg::issue_type   issue;
   hex27sf_pkg::factor_type  factor;
   hex27sf_pkg::product_type product;

   hex27sf_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_word (req_word),
      .busy     (busy),
      .issue    (issue)
   );

   hex27sf_factor u_factor (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .factor (factor)
   );

   hex27sf_product u_product (
      .clock   (clock),
      .reset   (reset),
      .factor  (factor),
      .product (product)
   );

   hex27sf_round_sat u_round_sat (
      .clock      (clock),
      .reset      (reset),
      .product    (product),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // an accepted point shows node 0 after the fixed pipeline latency
   a_first_node: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_strobe && (rsp_word.node_index == '0))
      else $error("node 0 not delivered at pipeline latency");

   // nodes of one point come out on consecutive cycles in order
   a_node_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_word.last_node |=>
         rsp_strobe && (rsp_word.node_index == $past(rsp_word.node_index) + 5'd1))
      else $error("node sequence broken");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.last_node == (rsp_word.node_index == hex27sf_pkg::LAST_NODE)))
      else $error("last flag does not match node 26");

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.shape_value <= hex27sf_pkg::SAT_HI_16)
                  && (rsp_word.shape_value >= hex27sf_pkg::SAT_LO_16))
      else $error("shape value outside saturation range");

endmodule

`default_nettype wire

// ===== tb/hex27_shape_function_eval_core_tb.sv =====
// Testbench for hex27_shape_function_eval_core: drives local points and checks all
// 27 shape-function words of each against an exact-product predictor.
// Depends on hex27sf_pkg and the core's RTL.

module hex27_shape_function_eval_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hex27sf_pkg::*;

   localparam int RSHIFT = 6 * FRAC_BITS + 3;
   localparam int ONE    = 1 << FRAC_BITS;
   localparam int HALF   = 1 << (FRAC_BITS - 1);
   localparam int GRID [5] = '{-ONE, -HALF, 0, HALF, ONE};

   // per node: position on the xi, eta and zeta axes
   localparam node_pos_type NODE_PLACE [NODE_COUNT] = '{
      '{POS_MINUS,  POS_MINUS,  POS_MINUS},  '{POS_PLUS,   POS_MINUS,  POS_MINUS},
      '{POS_PLUS,   POS_PLUS,   POS_MINUS},  '{POS_MINUS,  POS_PLUS,   POS_MINUS},
      '{POS_MINUS,  POS_MINUS,  POS_PLUS},   '{POS_PLUS,   POS_MINUS,  POS_PLUS},
      '{POS_PLUS,   POS_PLUS,   POS_PLUS},   '{POS_MINUS,  POS_PLUS,   POS_PLUS},
      '{POS_CENTER, POS_MINUS,  POS_MINUS},  '{POS_PLUS,   POS_CENTER, POS_MINUS},
      '{POS_CENTER, POS_PLUS,   POS_MINUS},  '{POS_MINUS,  POS_CENTER, POS_MINUS},
      '{POS_MINUS,  POS_MINUS,  POS_CENTER}, '{POS_PLUS,   POS_MINUS,  POS_CENTER},
      '{POS_PLUS,   POS_PLUS,   POS_CENTER}, '{POS_MINUS,  POS_PLUS,   POS_CENTER},
      '{POS_CENTER, POS_MINUS,  POS_PLUS},   '{POS_PLUS,   POS_CENTER, POS_PLUS},
      '{POS_CENTER, POS_PLUS,   POS_PLUS},   '{POS_MINUS,  POS_CENTER, POS_PLUS},
      '{POS_CENTER, POS_CENTER, POS_CENTER}, '{POS_CENTER, POS_CENTER, POS_MINUS},
      '{POS_CENTER, POS_CENTER, POS_PLUS},   '{POS_MINUS,  POS_CENTER, POS_CENTER},
      '{POS_PLUS,   POS_CENTER, POS_CENTER}, '{POS_CENTER, POS_MINUS,  POS_CENTER},
      '{POS_CENTER, POS_PLUS,   POS_CENTER}
   };

   typedef struct {
      req_type word;
      bit      drain_first;
      bit      steady;
   } point_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_word = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_word;

   point_item_type point_queue[$];
   rsp_type        node_expect[$];
   rsp_type        want;
   bit             word_taken = 1'b0;
   int             mismatch_count = 0;

   hex27_shape_function_eval_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_word   (req_word),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   initial forever #5 clock = ~clock;

   // exact product of the three 1-D factors, rounded once, then clamped
   function automatic rsp_type eval_shape_node(input req_type pt, input int node);
      longint       coord [3];
      node_pos_type place;
      pos_code_type code;
      longint       s;
      longint       num;
      logic [63:0]  mag;
      logic [191:0] prod;
      logic [191:0] scaled;
      bit           neg;
      longint       hi;
      longint       lo;
      longint       v;
      rsp_type      r;
      coord[0] = longint'($signed(pt.xi_coord));
      coord[1] = longint'($signed(pt.eta_coord));
      coord[2] = longint'($signed(pt.zeta_coord));
      place = NODE_PLACE[node];
      s = longint'(1) << FRAC_BITS;
      neg = 1'b0;
      prod = 192'd1;
      for (int a = 0; a < 3; a++) begin
         code = (a == 0) ? place.xi : (a == 1) ? place.eta : place.zeta;
         case (code)
            POS_MINUS: num = coord[a] * (coord[a] - s);
            POS_PLUS:  num = coord[a] * (coord[a] + s);
            default:   num = 2 * (s * s - coord[a] * coord[a]);
         endcase
         if (num < 0) begin
            neg = !neg;
            num = -num;
         end
         mag = num;
         prod = prod * {128'd0, mag};
      end
      // denominator is 2^(6F+3); round the magnitude half up
      prod = prod + (192'd1 << (RSHIFT - 1));
      scaled = prod >> RSHIFT;
      hi = longint'(1) << FRAC_BITS;
      if (hi > 32767) hi = 32767;
      lo = -(longint'(1) << (FRAC_BITS - 3));
      if (lo < -32768) lo = -32768;
      if (|scaled[191:40]) begin
         v = neg ? lo : hi;
      end else begin
         v = longint'(scaled[39:0]);
         if (neg) v = -v;
         if (v > hi) v = hi;
         if (v < lo) v = lo;
      end
      r.node_index  = NODE_W'(node);
      r.shape_value = v[VALUE_W-1:0];
      r.last_node   = (node == NODE_COUNT - 1);
      return r;
   endfunction

   function automatic int pick_coord();
      int v;
      case ($urandom_range(0, 3))
         0:       v = int'($urandom_range(0, 2 * ONE)) - ONE;
         1:       v = GRID[$urandom_range(0, 4)];
         2:       v = GRID[$urandom_range(0, 4)] + int'($urandom_range(0, 6)) - 3;
         default: v = int'($urandom_range(0, 64)) - 32;
      endcase
      if (v > ONE) v = ONE;
      if (v < -ONE) v = -ONE;
      return v;
   endfunction

   task automatic add_point(input int x, input int y, input int z,
                            input bit drain, input bit steady);
      point_item_type it;
      it.word.xi_coord   = COORD_W'(x);
      it.word.eta_coord  = COORD_W'(y);
      it.word.zeta_coord = COORD_W'(z);
      it.drain_first     = drain;
      it.steady          = steady;
      point_queue.push_back(it);
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // driver: a new word is offered only once the held one was taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || word_taken) begin
         if (point_queue.size() == 0
             || (point_queue[0].drain_first && node_expect.size() != 0)
             || (!point_queue[0].steady && $urandom_range(0, 99) < 33)) begin
            start <= 1'b0;
         end else begin
            req_word <= point_queue[0].word;
            start    <= 1'b1;
            point_queue.delete(0);
         end
      end
      word_taken = 1'b0;
   end

   // monitor: check results first, then queue the predictions of an accepted point
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (node_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected word for node %0d", rsp_word.node_index));
            end else begin
               want = node_expect.pop_front();
               if (rsp_word.node_index !== want.node_index)
                  report_mismatch($sformatf("node_index %0d, expected %0d",
                                            rsp_word.node_index, want.node_index));
               if (rsp_word.shape_value !== want.shape_value)
                  report_mismatch($sformatf("node %0d shape_value %0d, expected %0d",
                                            want.node_index, rsp_word.shape_value,
                                            want.shape_value));
               if (rsp_word.last_node !== want.last_node)
                  report_mismatch($sformatf("node %0d last_node %0b, expected %0b",
                                            want.node_index, rsp_word.last_node,
                                            want.last_node));
            end
         end
         if (start && !busy) begin
            for (int n = 0; n < NODE_COUNT; n++)
               node_expect.push_back(eval_shape_node(req_word, n));
            word_taken = 1'b1;
         end
      end
   end

   initial begin
      // directed: corners, center, half points, the -0.125 minimum, tiny and odd values
      for (int c = 0; c < 8; c++)
         add_point((c & 1) ? ONE : -ONE, (c & 2) ? ONE : -ONE, (c & 4) ? ONE : -ONE, 0, 0);
      add_point(0, 0, 0, 0, 0);
      add_point(HALF, HALF, HALF, 0, 0);
      add_point(-HALF, -HALF, -HALF, 0, 0);
      add_point(HALF, ONE, ONE, 0, 0);
      add_point(-HALF, -ONE, -ONE, 0, 0);
      add_point(ONE, -HALF, 0, 0, 0);
      add_point(1, -1, 1, 0, 0);
      add_point(ONE - 1, -ONE + 1, 1, 0, 0);
      add_point(-ONE, 0, ONE, 0, 0);
      add_point(0, ONE, -ONE, 0, 0);
      add_point(ONE / 3, -ONE / 3, 2 * ONE / 3, 0, 0);
      add_point(3, -5, 7, 0, 0);
      for (int i = 0; i < 190; i++)
         add_point(pick_coord(), pick_coord(), pick_coord(),
                   i == 0 || $urandom_range(0, 19) == 0, i >= 80 && i < 140);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (point_queue.size() != 0 || start) @(posedge clock);
      while (node_expect.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
sv/hex27sf_pkg.sv
sv/hex27sf_sequencer.sv
sv/hex27sf_factor.sv
sv/hex27sf_product.sv
sv/hex27sf_round_sat.sv
sv/hex27_shape_function_eval_core.sv
tb/hex27_shape_function_eval_core_tb.sv
